FILE: sv/cpcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle pair cover count: shared package
// Field widths, register indexes, request codes, shared types and helpers.
// ----------------------------------------------------------------------------
package cpcc_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int IDX_W    = 6;
  localparam int COORD_W  = 32;
  localparam int CNT_W    = 7;
  localparam int RAD_W    = 31;
  localparam int MARGIN_W = 8;
  localparam int CFG_W    = 31;
  localparam int CFG_IDX_W = 1;
  localparam int ROOT_W   = 32;
  localparam int STEP_W   = 5;
  localparam int UNIT_STEPS = 32;

  localparam logic [RAD_W-1:0]    RADIUS_RST = 31'd117440;
  localparam logic [MARGIN_W-1:0] MARGIN_RST = 8'd2;
  localparam logic [CNT_W-1:0]    COUNT_MAX  = 7'd127;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_RADIUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_MARGIN = 1'b1;

  // Request codes.
  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  // Status of an iterative arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Clamp a 34-bit signed value to the signed 32-bit range.
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [33:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  // Magnitude of a 33-bit signed value.
  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    logic [32:0] r;
    r = v[32] ? (~v + 33'd1) : v;
    return r;
  endfunction

endpackage

FILE: sv/cpcc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle pair cover count: channel interfaces
// Valid/ready channels for requests and for intersection results.
// ----------------------------------------------------------------------------
interface cpcc_in_if import cpcc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic [IDX_W-1:0]          index_a;
  logic [IDX_W-1:0]          index_b;

  modport source (output valid, req_type, point_x, point_y, index_a, index_b,
                  input ready);
  modport sink (input valid, req_type, point_x, point_y, index_a, index_b,
                output ready);
endinterface

interface cpcc_out_if import cpcc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] cross_x;
  logic signed [COORD_W-1:0] cross_y;
  logic [CNT_W-1:0]          near_count;
  logic                      last_of_pair;

  modport source (output valid, cross_x, cross_y, near_count, last_of_pair,
                  input ready);
  modport sink (input valid, cross_x, cross_y, near_count, last_of_pair,
                output ready);
endinterface

FILE: sv/circle_pair_cover_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle pair cover count: top level
// Point table with pair queries for circle intersections and neighbor counts.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch. An append stores one point in the table in the
// cycle of its transfer and is dropped once the table is full. A query reads
// its two centres from the table, and if the circles of radius scan_radius
// meet, two results leave on out_ch: the first intersection point, then the
// second with last_of_pair set, each with the count of stored points closer
// than scan_radius + near_margin.
// One request is handled at a time. An append, like a query that names an
// unloaded index, leaves the block idle. For a query with results, two
// square roots and two divisions share one unit each, and each count walks
// the table through its single read port, one entry per cycle, followed by
// the count pipeline and the output register.
// A query whose circles do not meet returns to idle from the range check or
// the square check.
// A stalled receiver holds the result in the output register; the block
// waits and accepts no request. Reset empties the table (no clearing pass)
// and loads the register defaults. Configuration is written through cfg_we.
// ----------------------------------------------------------------------------
module circle_pair_cover_count import cpcc_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  cpcc_in_if.sink              in_ch,
  cpcc_out_if.source           out_ch
);

  localparam int CAP = (MAX_POINTS < 127) ? MAX_POINTS : 127;
  localparam int TW  = $clog2(CAP + 1);
  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CW  = (TW > IDX_W) ? TW : IDX_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RDA, S_RDB, S_DIFF, S_RANGE, S_SQ, S_CHK, S_SQRT_S,
    S_SQRT_Q, S_MUL, S_DIV, S_PTS, S_CNT, S_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [RAD_W-1:0]    scan_radius;
  logic [MARGIN_W-1:0] near_margin;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_radius <= RADIUS_RST;
      near_margin <= MARGIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCAN_RADIUS: scan_radius <= cfg_data[RAD_W-1:0];
        CFG_NEAR_MARGIN: near_margin <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Request handshake and table fill.
  logic          in_xfer;
  logic [TW-1:0] total;
  logic          app_we;
  logic          idx_ok;
  point_t        app_pt;

  assign in_ch.ready = (state == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign app_we      = in_xfer && (in_ch.req_type == REQ_APPEND) &&
                       (total < TW'(CAP));
  assign idx_ok      = (CW'(in_ch.index_a) < CW'(total)) &&
                       (CW'(in_ch.index_b) < CW'(total));
  assign app_pt.x    = in_ch.point_x;
  assign app_pt.y    = in_ch.point_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (app_we) begin
      total <= total + TW'(1);
    end
  end

  // Memory read port, shared by the centre reads and the count walk.
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  point_t        rdata;
  logic [IDX_W-1:0] ia;
  logic [IDX_W-1:0] ib;
  logic [TW-1:0] cnt_idx;
  logic          issue;

  assign issue = (state == S_CNT) && (cnt_idx < total);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state)
      S_RDA: begin
        rd_en   = 1'b1;
        rd_addr = AW'(ia);
      end
      S_RDB: begin
        rd_en   = 1'b1;
        rd_addr = AW'(ib);
      end
      S_CNT: begin
        rd_en   = issue;
        rd_addr = AW'(cnt_idx);
      end
      default: ;
    endcase
  end

  cpcc_point_mem #(.DEPTH(MAX_POINTS)) u_mem (
    .clk   (clk),
    .we    (app_we),
    .waddr (AW'(total)),
    .wdata (app_pt),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // Geometry datapath registers.
  point_t             pa;
  logic [32:0]        adx;
  logic [32:0]        ady;
  logic               dx_neg;
  logic               dy_neg;
  logic signed [31:0] mx;
  logic signed [31:0] my;
  logic [63:0]        ax2;
  logic [63:0]        ay2;
  logic [63:0]        fr;
  logic [63:0]        d2;
  logic [ROOT_W-1:0]  s_r;
  logic [ROOT_W-1:0]  q_r;
  logic [ROOT_W-1:0]  ox_m;
  logic [ROOT_W-1:0]  oy_m;
  logic               phase;
  logic               k;
  point_t             p0;
  point_t             p1;
  logic [63:0]        lim2;
  logic               out_valid;

  logic [31:0]        two;
  logic [31:0]        lim;
  logic signed [32:0] dxw;
  logic signed [32:0] dyw;
  logic signed [32:0] sxw;
  logic signed [32:0] syw;
  logic [63:0]        d2_sum;
  logic               chk_pass;

  assign two = {scan_radius, 1'b0};
  assign lim = {1'b0, scan_radius} + {{(32-MARGIN_W){1'b0}}, near_margin};

  // Centre differences and sums, with B straight from the read port.
  assign dxw = {rdata.x[31], rdata.x} - {pa.x[31], pa.x};
  assign dyw = {rdata.y[31], rdata.y} - {pa.y[31], pa.y};
  assign sxw = {rdata.x[31], rdata.x} + {pa.x[31], pa.x};
  assign syw = {rdata.y[31], rdata.y} + {pa.y[31], pa.y};

  // Both squares within (2R)^2 in sum, and the centres distinct.
  assign d2_sum   = ax2 + ay2;
  assign chk_pass = !(ax2 > fr) && !(ay2 > (fr - ax2)) && (d2_sum != 64'd0);

  // Shared square root and divider.
  logic              sq_start;
  logic [63:0]       sq_rad;
  unit_stat_t        sq_stat;
  logic [ROOT_W-1:0] sq_root;
  logic              dv_start;
  logic [63:0]       dv_num;
  unit_stat_t        dv_stat;
  logic [ROOT_W-1:0] dv_quot;
  logic [31:0]       mul_a;

  assign sq_start = ((state == S_CHK) && chk_pass) ||
                    ((state == S_SQRT_S) && sq_stat.done);
  assign sq_rad   = (state == S_CHK) ? (fr - d2_sum) : d2;
  assign mul_a    = phase ? adx[31:0] : ady[31:0];
  assign dv_start = (state == S_MUL);
  assign dv_num   = (mul_a * s_r) + {32'd0, q_r};

  cpcc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_rad),
    .stat     (sq_stat),
    .root     (sq_root)
  );

  cpcc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (dv_num),
    .divisor  ({q_r, 1'b0}),
    .stat     (dv_stat),
    .quotient (dv_quot)
  );

  // Signed offsets and the two intersection points.
  logic signed [33:0] ox_e;
  logic signed [33:0] oy_e;
  logic signed [33:0] mx_e;
  logic signed [33:0] my_e;

  assign ox_e = dy_neg ? -$signed({2'b00, ox_m}) : $signed({2'b00, ox_m});
  assign oy_e = dx_neg ? -$signed({2'b00, oy_m}) : $signed({2'b00, oy_m});
  assign mx_e = {{2{mx[31]}}, mx};
  assign my_e = {{2{my[31]}}, my};

  // Count walk control.
  logic v1;
  logic v2;
  logic v3;
  logic cnt_clear;
  logic cnt_done;

  assign cnt_clear = (state == S_PTS) ||
                     ((state == S_OUT) && out_ch.ready && !k);
  assign cnt_done  = (state == S_CNT) && (cnt_idx == total) && !v1 && !v2 && !v3;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      phase     <= 1'b0;
      k         <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer && (in_ch.req_type == REQ_QUERY) && idx_ok) begin
            ia    <= in_ch.index_a;
            ib    <= in_ch.index_b;
            state <= S_RDA;
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin
          pa    <= rdata;
          state <= S_DIFF;
        end
        S_DIFF: begin
          adx    <= mag33(dxw);
          ady    <= mag33(dyw);
          dx_neg <= dxw[32];
          dy_neg <= dyw[32];
          mx     <= sxw[32:1];
          my     <= syw[32:1];
          state  <= S_RANGE;
        end
        S_RANGE: begin
          if ((adx > {1'b0, two}) || (ady > {1'b0, two})) begin
            state <= S_IDLE;
          end else begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          ax2   <= adx[31:0] * adx[31:0];
          ay2   <= ady[31:0] * ady[31:0];
          fr    <= two * two;
          state <= S_CHK;
        end
        S_CHK: begin
          d2 <= d2_sum;
          if (chk_pass) begin
            state <= S_SQRT_S;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SQRT_S: begin
          if (sq_stat.done) begin
            s_r   <= sq_root;
            state <= S_SQRT_Q;
          end
        end
        S_SQRT_Q: begin
          if (sq_stat.done) begin
            q_r   <= sq_root;
            phase <= 1'b0;
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_DIV;
        S_DIV: begin
          if (dv_stat.done) begin
            if (!phase) begin
              ox_m  <= dv_quot;
              phase <= 1'b1;
              state <= S_MUL;
            end else begin
              oy_m  <= dv_quot;
              state <= S_PTS;
            end
          end
        end
        S_PTS: begin
          p0.x  <= sat32(mx_e + ox_e);
          p0.y  <= sat32(my_e - oy_e);
          p1.x  <= sat32(mx_e - ox_e);
          p1.y  <= sat32(my_e + oy_e);
          lim2  <= lim * lim;
          k     <= 1'b0;
          state <= S_CNT;
        end
        S_CNT: begin
          if (cnt_done) begin
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_valid <= 1'b0;
            if (!k) begin
              k     <= 1'b1;
              state <= S_CNT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Count pipeline: read, distance per axis, squares, compare.
  point_t             cen;
  logic [CNT_W-1:0]   count;
  logic signed [32:0] cdx;
  logic signed [32:0] cdy;
  logic [32:0]        acx;
  logic [32:0]        acy;
  logic [31:0]        ax1;
  logic [31:0]        ay1;
  logic               ok2;
  logic [63:0]        sqx;
  logic [63:0]        sqy;
  logic               ok3;
  logic [64:0]        dist2;

  assign cen   = k ? p1 : p0;
  assign cdx   = {rdata.x[31], rdata.x} - {cen.x[31], cen.x};
  assign cdy   = {rdata.y[31], rdata.y} - {cen.y[31], cen.y};
  assign acx   = mag33(cdx);
  assign acy   = mag33(cdy);
  assign dist2 = {1'b0, sqx} + {1'b0, sqy};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    ax1 <= acx[31:0];
    ay1 <= acy[31:0];
    ok2 <= (acx < {1'b0, lim}) && (acy < {1'b0, lim});
    sqx <= ax1 * ax1;
    sqy <= ay1 * ay1;
    ok3 <= ok2;
  end

  always_ff @(posedge clk) begin
    if (cnt_clear) begin
      cnt_idx <= '0;
      count   <= '0;
    end else begin
      if (issue) begin
        cnt_idx <= cnt_idx + TW'(1);
      end
      if (v3 && ok3 && (dist2 < {1'b0, lim2}) && (count != COUNT_MAX)) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // Result channel.
  assign out_ch.valid        = out_valid;
  assign out_ch.cross_x      = cen.x;
  assign out_ch.cross_y      = cen.y;
  assign out_ch.near_count   = count;
  assign out_ch.last_of_pair = k;

endmodule

FILE: sv/cpcc_point_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle pair cover count: point table
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module cpcc_point_mem import cpcc_pkg::*; #(
  parameter int DEPTH = MAX_POINTS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  point_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output point_t        rdata
);

  point_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/cpcc_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle pair cover count: integer square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module cpcc_sqrt import cpcc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [63:0]       radicand,
  output unit_stat_t        stat,
  output logic [ROOT_W-1:0] root
);

  logic              running;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [63:0]       rad;
  logic [33:0]       rem;
  logic [35:0]       rem_sh;
  logic [35:0]       trial;

  assign stat.busy = running;
  assign stat.done = done;

  // Bring down two radicand bits and try the next root bit.
  assign rem_sh = {rem, rad[63:62]};
  assign trial  = {2'b00, root, 2'b01};

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start && !running) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(UNIT_STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start && !running) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (running) begin
      rad <= {rad[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= 34'(rem_sh - trial);
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[33:0];
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: sv/cpcc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle pair cover count: restoring divider
// 64-bit by 33-bit unsigned division whose quotient fits in 32 bits,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cpcc_div import cpcc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [63:0]       dividend,
  input  logic [32:0]       divisor,
  output unit_stat_t        stat,
  output logic [ROOT_W-1:0] quotient
);

  logic              running;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [31:0]       low;
  logic [32:0]       dsr;
  logic [33:0]       rem;
  logic [34:0]       rem_sh;

  assign stat.busy = running;
  assign stat.done = done;

  assign rem_sh = {rem, low[31]};

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start && !running) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(UNIT_STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath: the upper half is already below the divisor.
  always_ff @(posedge clk) begin
    if (start && !running) begin
      rem      <= {2'b00, dividend[63:32]};
      low      <= dividend[31:0];
      dsr      <= divisor;
      quotient <= '0;
    end else if (running) begin
      low <= {low[30:0], 1'b0};
      if (rem_sh >= {2'b00, dsr}) begin
        rem      <= 34'(rem_sh - {2'b00, dsr});
        quotient <= {quotient[ROOT_W-2:0], 1'b1};
      end else begin
        rem      <= rem_sh[33:0];
        quotient <= {quotient[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle pair cover count: testbench
// Appends points, queries pairs of them and checks every intersection point
// and neighbor count against a predictor kept in the testbench. Both channels
// idle at random and the radius and margin are changed between phases.
// ----------------------------------------------------------------------------
module tb;
  import cpcc_pkg::*;

  // Expected intersection result.
  typedef struct {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [CNT_W-1:0]          cnt;
    logic                      last;
  } cross_t;

  // Predicts the results of each accepted request and checks arriving ones.
  class cross_board;
    longint px[MAX_POINTS_DEF];
    longint py[MAX_POINTS_DEF];
    int     total;
    longint radius;
    longint margin;
    cross_t pending[$];
    int     errors;

    function void clear();
      total = 0;
      radius = RADIUS_RST;
      margin = MARGIN_RST;
      errors = 0;
    endfunction

    function automatic longint root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function automatic longint clamp(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function automatic longint offset(longint v, longint unsigned s, longint unsigned q);
      longint unsigned m;
      longint unsigned av;
      av = (v < 0) ? -v : v;
      m = (av * s + q) / (2 * q);
      return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic int neighbors(longint x, longint y);
      longint lim, ax, ay;
      int n;
      lim = radius + margin;
      n = 0;
      for (int i = 0; i < total; i++) begin
        ax = px[i] - x;
        ay = py[i] - y;
        if (ax < 0) ax = -ax;
        if (ay < 0) ay = -ay;
        if (ax < lim && ay < lim && ax * ax + ay * ay < lim * lim) n++;
      end
      return n > 127 ? 127 : n;
    endfunction

    // Note an accepted request and queue the results it must produce.
    function void note_request(logic rt, logic signed [31:0] x, logic signed [31:0] y,
                               int a, int b);
      longint dx, dy, mx, my, ox, oy;
      longint unsigned adx, ady, two, fr, ax2, ay2, d2, s, q;
      longint rx[2], ry[2];
      cross_t e;
      if (rt == REQ_APPEND) begin
        if (total < MAX_POINTS_DEF) begin
          px[total] = x;
          py[total] = y;
          total++;
        end
        return;
      end
      if (a >= total || b >= total) return;
      dx = px[b] - px[a];
      dy = py[b] - py[a];
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      two = 2 * radius;
      if (adx > two || ady > two) return;
      // The squares can exceed the signed 64-bit range, so stay unsigned.
      fr = two * two;
      ax2 = adx * adx;
      ay2 = ady * ady;
      if (ax2 > fr || ay2 > fr - ax2) return;
      d2 = ax2 + ay2;
      if (d2 == 0) return;
      s = root(fr - d2);
      q = root(d2);
      mx = (px[a] + px[b]) >>> 1;
      my = (py[a] + py[b]) >>> 1;
      ox = offset(dy, s, q);
      oy = offset(dx, s, q);
      rx[0] = clamp(mx + ox);
      ry[0] = clamp(my - oy);
      rx[1] = clamp(mx - ox);
      ry[1] = clamp(my + oy);
      for (int k = 0; k < 2; k++) begin
        e.cx = rx[k];
        e.cy = ry[k];
        e.cnt = neighbors(rx[k], ry[k]);
        e.last = (k == 1);
        pending = {pending, e};
      end
    endfunction

    // Check one accepted result against the oldest expectation.
    function void check_result(cross_t got);
      cross_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result x=%0d y=%0d", got.cx, got.cy);
        return;
      end
      e = pending.pop_front();
      if (got.cx !== e.cx || got.cy !== e.cy || got.cnt !== e.cnt || got.last !== e.last)
        begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                   e.cx, e.cy, e.cnt, e.last, got.cx, got.cy, got.cnt, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  bit calm;
  int stored;
  cross_board board;

  cpcc_in_if  in_ch ();
  cpcc_out_if out_ch ();

  circle_pair_cover_count i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety limit on the whole run.
  initial begin
    #50ms;
    $display("tb: done, errors");
    $finish;
  end

  // Receiver with random stalls; checks every transfer.
  initial begin
    cross_t got;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        got.cx = out_ch.cross_x;
        got.cy = out_ch.cross_y;
        got.cnt = out_ch.near_count;
        got.last = out_ch.last_of_pair;
        board.check_result(got);
      end
      out_ch.ready <= calm || ($urandom_range(99) >= 17);
    end
  end

  // Send one request, idling at random first. Valid stays high after the
  // transfer so that back-to-back requests need no extra edge; an idle
  // stretch or a drain drops it.
  task automatic send(logic rt, logic [31:0] x, logic [31:0] y, int a, int b);
    if (!calm && $urandom_range(99) < 17) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(99) < 17);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= rt;
    in_ch.point_x <= x;
    in_ch.point_y <= y;
    in_ch.index_a <= IDX_W'(a);
    in_ch.index_b <= IDX_W'(b);
    do @(posedge clk); while (!in_ch.ready);
    board.note_request(rt, x, y, a, b);
    if (rt == REQ_APPEND && stored < MAX_POINTS_DEF) stored++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SCAN_RADIUS) board.radius = v;
    else board.margin = v[MARGIN_W-1:0];
  endtask

  // Append a point near a random stored one, or anywhere.
  task automatic append_near(int spread);
    logic [31:0] x, y;
    int k;
    if (stored > 0 && $urandom_range(9) != 0) begin
      k = $urandom_range(stored - 1);
      x = 32'(board.px[k] + $signed($urandom_range(2 * spread)) - spread);
      y = 32'(board.py[k] + $signed($urandom_range(2 * spread)) - spread);
    end else begin
      x = $urandom;
      y = $urandom;
    end
    send(REQ_APPEND, x, y, $urandom, $urandom);
  endtask

  task automatic query_rand();
    int a, b;
    if ($urandom_range(19) == 0 || stored == 0) begin
      a = $urandom_range(63);
      b = $urandom_range(63);
    end else begin
      a = $urandom_range(stored - 1);
      b = $urandom_range(stored - 1);
    end
    send(REQ_QUERY, $urandom, $urandom, a, b);
  endtask

  initial begin
    int spread;
    board = new();
    board.clear();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_SCAN_RADIUS;
    cfg_data = '0;
    calm = 1'b0;
    stored = 0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_APPEND;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.index_a = '0;
    in_ch.index_b = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a query on an empty table, a same-centre pair, a tangent pair,
    // a far pair, and points at the coordinate extremes.
    send(REQ_QUERY, '0, '0, 0, 0);
    send(REQ_APPEND, 32'd0, 32'd0, 63, 63);
    send(REQ_APPEND, 32'd234880, 32'd0, 0, 0);
    send(REQ_APPEND, 32'd100000, 32'd50000, 0, 0);
    send(REQ_APPEND, 32'd0, 32'd0, 0, 0);
    send(REQ_APPEND, 32'd900000, 32'd0, 0, 0);
    send(REQ_APPEND, 32'h7FFF_FFF0, 32'h8000_0005, 0, 0);
    send(REQ_APPEND, 32'h7FFF_FF00, 32'h8000_0100, 0, 0);
    send(REQ_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
    send(REQ_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    send(REQ_QUERY, '0, '0, 0, 0);
    send(REQ_QUERY, '1, '1, 0, 1);
    send(REQ_QUERY, '0, '0, 0, 2);
    send(REQ_QUERY, '0, '0, 0, 3);
    send(REQ_QUERY, '0, '0, 0, 4);
    send(REQ_QUERY, '0, '0, 5, 6);
    send(REQ_QUERY, '0, '0, 7, 8);
    send(REQ_QUERY, '0, '0, 2, 63);
    send(REQ_QUERY, '0, '0, 20, 1);
    drain();
    write_reg(CFG_SCAN_RADIUS, 31'h7FFF_FFFF);
    write_reg(CFG_NEAR_MARGIN, CFG_W'(8'hFF));
    send(REQ_QUERY, '0, '0, 5, 7);
    send(REQ_QUERY, '0, '0, 0, 7);
    send(REQ_QUERY, '0, '0, 8, 5);
    write_reg(CFG_SCAN_RADIUS, 31'd0);
    write_reg(CFG_NEAR_MARGIN, 31'd0);
    send(REQ_QUERY, '0, '0, 0, 1);
    send(REQ_QUERY, '0, '0, 0, 3);

    // Random phases with different settings; the table fills up and drops.
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(CFG_SCAN_RADIUS, CFG_W'(RADIUS_RST));
          write_reg(CFG_NEAR_MARGIN, CFG_W'(MARGIN_RST));
        end
        1: write_reg(CFG_SCAN_RADIUS, CFG_W'($urandom_range(1000, 1)));
        2: begin
          write_reg(CFG_SCAN_RADIUS,
                    CFG_W'($urandom_range(31'h7FFF_FFFF, 31'h1000_0000)));
          write_reg(CFG_NEAR_MARGIN, CFG_W'($urandom_range(255)));
        end
        3: write_reg(CFG_SCAN_RADIUS, CFG_W'($urandom_range(5000000, 100000)));
        default: write_reg(CFG_NEAR_MARGIN, CFG_W'(8'hFF));
      endcase
      calm = (ph == 3);
      spread = board.radius > 100000000 ? 100000000 : int'(board.radius) * 3 / 2 + 1;
      for (int n = 0; n < 215; n++) begin
        if ($urandom_range(2) == 0 && stored < MAX_POINTS_DEF + 4) append_near(spread);
        else query_rand();
        if (n == 100) drain();
      end
    end
    calm = 1'b0;

    drain();
    if (board.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
